### hdl/gpio_ovr_pkg.sv
package gpio_ovr_pkg;

	// Fixed widths of the bus and pad fields
	localparam int PORT_W  = 8;
	localparam int DRIVE_W = 2 * PORT_W;

	// Request kinds
	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_EVENT = 2'd2,
		KIND_OVR   = 2'd3
	} kind_t;

	// Bus register selects
	typedef enum logic [1:0] {
		SEL_PIN   = 2'd0,
		SEL_DIR   = 2'd1,
		SEL_LATCH = 2'd2,
		SEL_MASK  = 2'd3
	} reg_sel_t;

	// Observed pin levels (any other code: neither)
	localparam logic [1:0] LVL_LOW  = 2'd0;
	localparam logic [1:0] LVL_HIGH = 2'd1;

	// Per-pin drive codes
	localparam logic [1:0] DRIVE_OPEN   = 2'd0;
	localparam logic [1:0] DRIVE_PULLUP = 2'd1;
	localparam logic [1:0] DRIVE_LOW    = 2'd2;
	localparam logic [1:0] DRIVE_HIGH   = 2'd3;

	// One request as held in the input stage
	typedef struct packed {
		kind_t              kind;
		reg_sel_t           reg_select;
		logic [PORT_W-1:0]  write_data;
		logic [2:0]         pin_index;
		logic [1:0]         pin_level;
		logic [PORT_W-1:0]  dir_ovr_en;
		logic [PORT_W-1:0]  dir_ovr_val;
		logic [PORT_W-1:0]  val_ovr_en;
		logic [PORT_W-1:0]  val_ovr_val;
	} req_t;

	// Port state, zero-extended to the full port width
	typedef struct packed {
		logic [PORT_W-1:0]  sampled;
		logic [PORT_W-1:0]  dir;
		logic [PORT_W-1:0]  latch;
		logic [PORT_W-1:0]  mask;
		logic [PORT_W-1:0]  dir_en;
		logic [PORT_W-1:0]  dir_val;
		logic [PORT_W-1:0]  val_en;
		logic [PORT_W-1:0]  val_val;
		logic               irq;
	} port_state_t;

endpackage

### hdl/gpio_ovr_regs.sv
module gpio_ovr_regs
	import gpio_ovr_pkg::*;
#(
	parameter int PIN_COUNT = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  req_t                req,
	output port_state_t         cur_state,
	output port_state_t         nxt_state,
	output logic [PORT_W-1:0]   rd_data
);

	logic [PIN_COUNT-1:0] sampled_q, dir_q, latch_q, mask_q;
	logic [PIN_COUNT-1:0] dir_en_q, dir_val_q, val_en_q, val_val_q;
	logic                 irq_q;

	logic [PIN_COUNT-1:0] sampled_d, dir_d, latch_d, mask_d;
	logic [PIN_COUNT-1:0] dir_en_d, dir_val_d, val_en_d, val_val_d;
	logic                 irq_d;

	logic [PIN_COUNT-1:0] wdata;
	logic [PORT_W-1:0]    evt_onehot;
	logic [PIN_COUNT-1:0] evt_bit;
	logic [PIN_COUNT-1:0] rd_bits;

	// Pins past PIN_COUNT drop out of the one-hot, so such events do nothing
	assign wdata      = req.write_data[PIN_COUNT-1:0];
	assign evt_onehot = PORT_W'(1) << req.pin_index;
	assign evt_bit    = evt_onehot[PIN_COUNT-1:0];

	// Next state for the request in the input stage
	always_comb begin
		sampled_d = sampled_q;
		dir_d     = dir_q;
		latch_d   = latch_q;
		mask_d    = mask_q;
		dir_en_d  = dir_en_q;
		dir_val_d = dir_val_q;
		val_en_d  = val_en_q;
		val_val_d = val_val_q;
		irq_d     = irq_q;
		rd_bits   = '0;
		case (req.kind)
			KIND_READ: begin
				case (req.reg_select)
					SEL_PIN:   rd_bits = sampled_q;
					SEL_DIR:   rd_bits = dir_q;
					SEL_LATCH: rd_bits = latch_q;
					SEL_MASK:  rd_bits = mask_q;
					default:   rd_bits = '0;
				endcase
			end
			KIND_WRITE: begin
				case (req.reg_select)
					SEL_PIN:   latch_d = latch_q ^ wdata;   // toggle latch
					SEL_DIR:   dir_d   = wdata;
					SEL_LATCH: latch_d = wdata;
					SEL_MASK:  mask_d  = wdata;
					default:   latch_d = latch_q;
				endcase
			end
			KIND_EVENT: begin
				if (req.pin_level == LVL_LOW) begin
					sampled_d = sampled_q & ~evt_bit;
				end else if (req.pin_level == LVL_HIGH) begin
					sampled_d = sampled_q | evt_bit;
				end
				// neither level still counts as a change
				if (|(mask_q & evt_bit)) begin
					irq_d = ~irq_q;
				end
			end
			KIND_OVR: begin
				dir_en_d  = req.dir_ovr_en[PIN_COUNT-1:0];
				dir_val_d = req.dir_ovr_val[PIN_COUNT-1:0];
				val_en_d  = req.val_ovr_en[PIN_COUNT-1:0];
				val_val_d = req.val_ovr_val[PIN_COUNT-1:0];
			end
			default: rd_bits = '0;
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sampled_q <= '0;
			dir_q     <= '0;
			latch_q   <= '0;
			mask_q    <= '0;
			dir_en_q  <= '0;
			dir_val_q <= '0;
			val_en_q  <= '0;
			val_val_q <= '0;
			irq_q     <= 1'b0;
		end else if (advance) begin
			sampled_q <= sampled_d;
			dir_q     <= dir_d;
			latch_q   <= latch_d;
			mask_q    <= mask_d;
			dir_en_q  <= dir_en_d;
			dir_val_q <= dir_val_d;
			val_en_q  <= val_en_d;
			val_val_q <= val_val_d;
			irq_q     <= irq_d;
		end
	end

	// Zero-extend to the port width; unstored bits read as zero
	always_comb begin
		cur_state = '0;
		nxt_state = '0;
		rd_data   = '0;
		cur_state.sampled[PIN_COUNT-1:0] = sampled_q;
		cur_state.dir[PIN_COUNT-1:0]     = dir_q;
		cur_state.latch[PIN_COUNT-1:0]   = latch_q;
		cur_state.mask[PIN_COUNT-1:0]    = mask_q;
		cur_state.dir_en[PIN_COUNT-1:0]  = dir_en_q;
		cur_state.dir_val[PIN_COUNT-1:0] = dir_val_q;
		cur_state.val_en[PIN_COUNT-1:0]  = val_en_q;
		cur_state.val_val[PIN_COUNT-1:0] = val_val_q;
		cur_state.irq                    = irq_q;
		nxt_state.sampled[PIN_COUNT-1:0] = sampled_d;
		nxt_state.dir[PIN_COUNT-1:0]     = dir_d;
		nxt_state.latch[PIN_COUNT-1:0]   = latch_d;
		nxt_state.mask[PIN_COUNT-1:0]    = mask_d;
		nxt_state.dir_en[PIN_COUNT-1:0]  = dir_en_d;
		nxt_state.dir_val[PIN_COUNT-1:0] = dir_val_d;
		nxt_state.val_en[PIN_COUNT-1:0]  = val_en_d;
		nxt_state.val_val[PIN_COUNT-1:0] = val_val_d;
		nxt_state.irq                    = irq_d;
		rd_data[PIN_COUNT-1:0]           = rd_bits;
	end

endmodule

### hdl/gpio_ovr_drive.sv
module gpio_ovr_drive
	import gpio_ovr_pkg::*;
(
	input  port_state_t         state,
	output logic [PORT_W-1:0]   eff_dir,
	output logic [DRIVE_W-1:0]  drive
);

	// Direction override replaces the direction bit where enabled
	assign eff_dir = (state.dir & ~state.dir_en) | (state.dir_val & state.dir_en);

	// Per-pin drive code; unstored pins have zero state and come out open
	always_comb begin
		drive = '0;
		for (int i = 0; i < PORT_W; i++) begin
			if (!eff_dir[i]) begin
				drive[2*i +: 2] = state.latch[i] ? DRIVE_PULLUP : DRIVE_OPEN;
			end else if (state.val_en[i]) begin
				drive[2*i +: 2] = state.val_val[i] ? DRIVE_HIGH : DRIVE_LOW;
			end else begin
				drive[2*i +: 2] = state.latch[i] ? DRIVE_HIGH : DRIVE_LOW;
			end
		end
	end

endmodule

### hdl/gpio_port_with_overrides.sv
// GPIO port with direction and output value overrides. Each request (bus read,
// bus write, pin level event or override update) is taken into the input
// register, a new request every clock unless held by a stalled result, and
// moves on into the result register once that register is free. Every
// result carries the read byte (zero unless a read), the effective direction,
// the 2-bit drive code of each pin and the pin-change interrupt level, all as
// they stand after the request. A stalled result holds the input stage, which
// takes one more request meanwhile only if that stage was empty.
module gpio_port_with_overrides
	import gpio_ovr_pkg::*;
#(
	parameter int PIN_COUNT = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          kind,
	input  logic [1:0]          reg_select,
	input  logic [7:0]          write_data,
	input  logic [2:0]          pin_index,
	input  logic [1:0]          pin_level,
	input  logic [7:0]          dir_override_enable,
	input  logic [7:0]          dir_override_value,
	input  logic [7:0]          value_override_enable,
	input  logic [7:0]          value_override_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          read_data,
	output logic [7:0]          effective_direction,
	output logic [15:0]         pin_drive,
	output logic                change_irq_line
);

	logic                valid_s1;
	req_t                req_s1;
	logic                advance;
	port_state_t         cur_state;
	port_state_t         nxt_state;
	logic [PORT_W-1:0]   rd_data;
	logic [PORT_W-1:0]   eff_dir;
	logic [DRIVE_W-1:0]  drive;

	logic                out_valid_q;
	logic [PORT_W-1:0]   read_data_q;
	logic [PORT_W-1:0]   eff_dir_q;
	logic [DRIVE_W-1:0]  drive_q;
	logic                irq_q;

	// Handshake: input stage moves on whenever the result register is free
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.kind        <= kind_t'(kind);
			req_s1.reg_select  <= reg_sel_t'(reg_select);
			req_s1.write_data  <= write_data;
			req_s1.pin_index   <= pin_index;
			req_s1.pin_level   <= pin_level;
			req_s1.dir_ovr_en  <= dir_override_enable;
			req_s1.dir_ovr_val <= dir_override_value;
			req_s1.val_ovr_en  <= value_override_enable;
			req_s1.val_ovr_val <= value_override_value;
		end
	end

	// Port registers and their update
	gpio_ovr_regs #(
		.PIN_COUNT (PIN_COUNT)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.req       (req_s1),
		.cur_state (cur_state),
		.nxt_state (nxt_state),
		.rd_data   (rd_data)
	);

	// Pad drive from the updated state
	gpio_ovr_drive u_drive (
		.state   (nxt_state),
		.eff_dir (eff_dir),
		.drive   (drive)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= rd_data;
			eff_dir_q   <= eff_dir;
			drive_q     <= drive;
			irq_q       <= nxt_state.irq;
		end
	end

	assign out_valid           = out_valid_q;
	assign read_data           = read_data_q;
	assign effective_direction = eff_dir_q;
	assign pin_drive           = drive_q;
	assign change_irq_line     = irq_q;

	// Checks
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input held without a stalled result");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced request produced no result");

	a_irq_only_on_event: assert property (@(posedge clk) disable iff (!arst_n)
		(!advance || req_s1.kind != KIND_EVENT) |=> $stable(cur_state.irq))
		else $error("interrupt line changed without a pin event");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && req_s1.kind != KIND_READ) |=> (read_data_q == '0))
		else $error("read data nonzero for a non-read request");

endmodule
